@@ hw/rtl/psvm_pkg.sv @@
// Package for the polyphonic sample voice mixer: sizes, command codes, status codes, sequencer state codes.
// No dependencies.
package psvm_pkg;

    localparam int MAX_VOICES       = 16;
    localparam int NUM_SOUNDS       = 128;
    localparam int SAMPLE_MEM_WORDS = 1048576;

    localparam int VOICE_W  = $clog2(MAX_VOICES);
    localparam int SOUND_W  = $clog2(NUM_SOUNDS);
    localparam int ADDR_W   = $clog2(SAMPLE_MEM_WORDS);
    localparam int LEN_W    = ADDR_W + 1;
    localparam int COUNT_W  = $clog2(MAX_VOICES + 1);
    localparam int SUM_W    = 16 + VOICE_W + 1;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_DEFINE = 2'd1,
        CMD_PLAY   = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DROPPED = 2'd1,
        ST_CLIPPED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VREAD,
        S_SREAD,
        S_MREAD,
        S_ACCUM,
        S_DONE
    } state_t;

endpackage

@@ hw/rtl/psvm_sample_ram.sv @@
// Sample word memory: one write port, one registered read port.
// Depends on psvm_pkg.
module psvm_sample_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [psvm_pkg::ADDR_W-1:0]  waddr,
    input  logic [15:0]                  wdata,
    input  logic [psvm_pkg::ADDR_W-1:0]  raddr,
    output logic [15:0]                  rdata
);
    import psvm_pkg::*;

    logic [15:0] mem [SAMPLE_MEM_WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/polyphonic_sample_voice_mixer.sv @@
// Top level of the polyphonic sample voice mixer: sound table, voice table, tick sequencer.
// Depends on psvm_pkg and psvm_sample_ram.
//
// One input item gives one result item. Write, define and play items go from
// acceptance through the done state to the output register. A tick walks the
// voice slots one at a time: an idle slot is passed over in the voice read state,
// an active slot goes through voice table read, sound table read, sample memory
// read and accumulate; the single read port of each table memory sets this order.
// The input is taken only while no item is in progress; the finished
// result sits in an output register until taken. Sound and voice tables are
// cleared with valid bits at reset; the sample memory is never cleared and
// unwritten words read as anything. tdata in: cmd[1:0], sound_id[8:2],
// mem_address[28:9], sample_value[44:29], sound_length[65:45], zero fill to 72 bits.
// tdata out: mixed_sample[15:0], status[17:16], active_voices[22:18], zero fill.
module polyphonic_sample_voice_mixer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // cmd, sound_id, mem_address, sample_value, sound_length
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // mixed_sample, status, active_voices
);
    import psvm_pkg::*;

    // input fields
    logic [1:0]        in_cmd;
    logic [6:0]        in_sid;
    logic [ADDR_W-1:0] in_addr;
    logic [15:0]       in_value;
    logic [LEN_W-1:0]  in_len;
    assign in_cmd   = s_tdata[1:0];
    assign in_sid   = s_tdata[8:2];
    assign in_addr  = s_tdata[28:9];
    assign in_value = s_tdata[44:29];
    assign in_len   = s_tdata[65:45];

    logic accept;
    assign accept = s_tvalid && s_tready;

    // latched item
    logic [1:0]        cmd_reg;
    logic [6:0]        sid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [15:0]       value_reg;
    logic [LEN_W-1:0]  len_reg;

    // sound table memory: start/size; defined bits in flops
    logic [ADDR_W+LEN_W-1:0] snd_mem [NUM_SOUNDS];
    logic [ADDR_W+LEN_W-1:0] snd_rd;
    logic [NUM_SOUNDS-1:0]   snd_def_reg;
    logic                    snd_we;
    logic [SOUND_W-1:0]      snd_waddr, snd_raddr;
    logic [ADDR_W+LEN_W-1:0] snd_wdata;

    // voice table memory: sound id and position; active bits in flops
    logic [6+LEN_W:0]        vc_mem [MAX_VOICES];
    logic [6+LEN_W:0]        vc_rd;
    logic [MAX_VOICES-1:0]   vact_reg, vact_next;
    logic                    vc_we;
    logic [VOICE_W-1:0]      vc_waddr;
    logic [6+LEN_W:0]        vc_wdata;

    state_t state_reg, state_next;
    logic [VOICE_W-1:0]  vc_reg, vc_next;
    logic                vlast_reg, vlast_next;  // all slots visited; also marks a skipped slot for accumulate
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [6:0]          vsid_reg, vsid_next;
    logic [LEN_W-1:0]    vpos_reg, vpos_next;
    logic [ADDR_W-1:0]   saddr_reg, saddr_next;
    logic                m_valid_reg, m_valid_next;
    logic [15:0]         mix_reg, mix_next;
    logic [1:0]          stat_reg, stat_next;
    logic [NUM_SOUNDS-1:0] snd_def_next;

    always_ff @(posedge clk)
    begin
        if (snd_we)
        begin
            snd_mem[snd_waddr] <= snd_wdata;
        end
        snd_rd <= snd_mem[snd_raddr];
        if (vc_we)
        begin
            vc_mem[vc_waddr] <= vc_wdata;
        end
        vc_rd <= vc_mem[vc_reg];
    end

    // sample memory
    logic              smp_we;
    logic [ADDR_W-1:0] smp_raddr;
    logic [15:0]       smp_rd;
    psvm_sample_ram u_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (addr_reg),
        .wdata (value_reg),
        .raddr (smp_raddr),
        .rdata (smp_rd)
    );

    // lowest free slot
    logic               free_found;
    logic [VOICE_W-1:0] free_idx;
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_VOICES - 1; i >= 0; i--)
        begin
            if (!vact_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VOICE_W'(i);
            end
        end
    end

    logic [LEN_W-1:0] sat_len;
    assign sat_len = (len_reg > LEN_W'(SAMPLE_MEM_WORDS)) ? LEN_W'(SAMPLE_MEM_WORDS)
                                                         : len_reg;
    logic [ADDR_W-1:0] cur_start;
    logic [LEN_W-1:0]  cur_size;
    assign cur_start = snd_rd[ADDR_W+LEN_W-1:LEN_W];
    assign cur_size  = snd_rd[LEN_W-1:0];
    logic sid_ok;
    assign sid_ok = (int'(vsid_reg) < NUM_SOUNDS) && snd_def_reg[vsid_reg[SOUND_W-1:0]];
    logic [LEN_W-1:0] pos_inc;
    assign pos_inc = vpos_reg + LEN_W'(1);

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign snd_raddr = vc_rd[LEN_W+SOUND_W-1:LEN_W];
    // sample address goes to the memory in the cycle it is formed
    assign smp_raddr = saddr_next;

    always_comb
    begin
        state_next   = state_reg;
        vc_next      = vc_reg;
        vlast_next   = vlast_reg;
        sum_next     = sum_reg;
        vsid_next    = vsid_reg;
        vpos_next    = vpos_reg;
        saddr_next   = saddr_reg;
        vact_next    = vact_reg;
        snd_def_next = snd_def_reg;
        m_valid_next = m_valid_reg;
        mix_next     = mix_reg;
        stat_next    = stat_reg;
        snd_we       = 1'b0;
        snd_waddr    = sid_reg[SOUND_W-1:0];
        snd_wdata    = {addr_reg, sat_len};
        vc_we        = 1'b0;
        vc_waddr     = vc_reg;
        vc_wdata     = {sid_reg, LEN_W'(0)};
        smp_we       = 1'b0;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DONE;
                    vc_next    = '0;
                    vlast_next = 1'b0;
                    sum_next   = '0;
                    if (in_cmd == CMD_TICK)
                    begin
                        state_next = S_VREAD;
                    end
                end
            end
            S_VREAD:
            begin
                // vc_rd valid next cycle for slot vc_reg
                if (vact_reg[vc_reg])
                begin
                    state_next = S_SREAD;
                end
                else if (vc_reg == VOICE_W'(MAX_VOICES - 1))
                begin
                    vlast_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    vc_next = vc_reg + VOICE_W'(1);
                end
            end
            S_SREAD:
            begin
                vsid_next  = vc_rd[6+LEN_W:LEN_W];
                vpos_next  = vc_rd[LEN_W-1:0];
                state_next = S_MREAD;
            end
            S_MREAD:
            begin
                if (!sid_ok || vpos_reg >= cur_size)
                begin
                    vact_next[vc_reg] = 1'b0;
                    state_next = S_ACCUM;
                    vlast_next = 1'b0;
                    saddr_next = saddr_reg;
                    vsid_next  = vsid_reg;
                    vpos_next  = vpos_reg;
                    // mark skip by forcing size path: handled via vlast as skip flag
                    vlast_next = 1'b1;
                end
                else
                begin
                    saddr_next = cur_start + vpos_reg[ADDR_W-1:0];
                    vc_we      = 1'b1;
                    vc_wdata   = {vsid_reg, pos_inc};
                    if (pos_inc >= cur_size)
                    begin
                        vact_next[vc_reg] = 1'b0;
                    end
                    state_next = S_ACCUM;
                    vlast_next = 1'b0;
                end
            end
            S_ACCUM:
            begin
                // sample read done: smp_rd holds word of saddr_reg
                if (!vlast_reg)
                begin
                    sum_next = sum_reg + SUM_W'($signed(smp_rd));
                end
                vlast_next = 1'b0;
                if (vc_reg == VOICE_W'(MAX_VOICES - 1))
                begin
                    vlast_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    vc_next    = vc_reg + VOICE_W'(1);
                    state_next = S_VREAD;
                end
            end
            S_DONE:
            begin
                stat_next = ST_OK;
                mix_next  = '0;
                case (cmd_reg)
                    CMD_WRITE:
                    begin
                        smp_we = 1'b1;
                    end
                    CMD_DEFINE:
                    begin
                        if (int'(sid_reg) < NUM_SOUNDS)
                        begin
                            snd_we = 1'b1;
                            snd_def_next[sid_reg[SOUND_W-1:0]] = 1'b1;
                        end
                    end
                    CMD_PLAY:
                    begin
                        if (free_found)
                        begin
                            vc_we    = 1'b1;
                            vc_waddr = free_idx;
                            vact_next[free_idx] = 1'b1;
                        end
                        else
                        begin
                            stat_next = ST_DROPPED;
                        end
                    end
                    default:
                    begin
                        if ($signed(sum_reg) > $signed(SUM_W'(32767)))
                        begin
                            mix_next  = 16'h7fff;
                            stat_next = ST_CLIPPED;
                        end
                        else if ($signed(sum_reg) < $signed(-SUM_W'(32768)))
                        begin
                            mix_next  = 16'h8000;
                            stat_next = ST_CLIPPED;
                        end
                        else
                        begin
                            mix_next = sum_reg[15:0];
                        end
                    end
                endcase
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    logic [COUNT_W-1:0] act_cnt;
    always_comb
    begin
        act_cnt = '0;
        for (int i = 0; i < MAX_VOICES; i++)
        begin
            act_cnt = act_cnt + COUNT_W'(vact_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vact_reg    <= '0;
            snd_def_reg <= '0;
            m_valid_reg <= 1'b0;
            vc_reg      <= '0;
            vlast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vact_reg    <= vact_next;
            snd_def_reg <= snd_def_next;
            m_valid_reg <= m_valid_next;
            vc_reg      <= vc_next;
            vlast_reg   <= vlast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= in_cmd;
            sid_reg   <= in_sid;
            addr_reg  <= in_addr;
            value_reg <= in_value;
            len_reg   <= in_len;
        end
        sum_reg   <= sum_next;
        vsid_reg  <= vsid_next;
        vpos_reg  <= vpos_next;
        saddr_reg <= saddr_next;
        mix_reg   <= mix_next;
        stat_reg  <= stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, act_cnt, stat_reg, mix_reg};
endmodule
